// ===== src/assert_macros.svh =====
// Assertion macros shared by the slew limiter RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_PROP(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Expression must never be true out of reset.
`define ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`endif

// ===== src/jasl_pkg.sv =====
// Types and constants for the joint angle slew limiter.
// No dependencies; imported by jasl_lane, jasl_merge and the top level.
`timescale 1ns / 1ps
`default_nettype none

package jasl_pkg;

  localparam int NUM_LANES  = 6;
  localparam int ANGLE_W    = 16;
  localparam int STEP_W     = 15;
  localparam int MASK_W     = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_MASK  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_J0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_J1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_J2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_J3 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_J4 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_J5 = 3'd7;

  localparam logic [STEP_W-1:0] MAX_STEP_RST = 15'd327;

  // event codes
  localparam logic [1:0] EVT_NONE  = 2'd0;
  localparam logic [1:0] EVT_START = 2'd1;
  localparam logic [1:0] EVT_STOP  = 2'd2;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               moving;
  } lane_res_t;

  typedef struct packed {
    logic [1:0]                   evt;
    logic                         moving;
    logic [NUM_LANES*ANGLE_W-1:0] angles;
  } result_t;

endpackage

`default_nettype wire

// ===== src/jasl_lane.sv =====
// One joint lane: command, wrapped difference, clamp and angle update.
// Depends on jasl_pkg; holds the joint's current angle.
`timescale 1ns / 1ps
`default_nettype none

module jasl_lane #(
  parameter bit ACTIVE = 1'b1,
  parameter int THRESH = 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step_en,
  input  wire logic                          neg,
  input  wire logic [jasl_pkg::ANGLE_W-1:0]  offset,
  input  wire logic [jasl_pkg::STEP_W-1:0]   max_step,
  input  wire logic [jasl_pkg::ANGLE_W-1:0]  target,
  output jasl_pkg::lane_res_t                res
);
  import jasl_pkg::*;

  localparam int XW = ANGLE_W + 1;

  logic [ANGLE_W-1:0] angle_r;
  logic [ANGLE_W-1:0] angle_nxt;
  logic [ANGLE_W-1:0] tgt;
  logic [ANGLE_W-1:0] cmd;
  logic [ANGLE_W-1:0] diff;
  logic [XW-1:0]      diff_x;
  logic [XW-1:0]      mag;
  logic [XW-1:0]      lim_x;
  logic [XW-1:0]      lim_neg;
  logic [XW-1:0]      step;

  always_comb begin
    tgt     = neg ? ANGLE_W'(16'd0 - target) : target;
    cmd     = ANGLE_W'(tgt + offset);
    diff    = ANGLE_W'(cmd - angle_r);
    diff_x  = {diff[ANGLE_W-1], diff};
    // half turn reads as -32768, magnitude 32768
    mag     = diff[ANGLE_W-1] ? XW'(17'd0 - diff_x) : diff_x;
    lim_x   = {2'b00, max_step};
    lim_neg = XW'(17'd0 - lim_x);
    if ($signed(diff_x) > $signed(lim_x)) begin
      step = lim_x;
    end else if ($signed(diff_x) < $signed(lim_neg)) begin
      step = lim_neg;
    end else begin
      step = diff_x;
    end
    angle_nxt = ACTIVE ? ANGLE_W'(angle_r + step[ANGLE_W-1:0]) : angle_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
    end else if (step_en) begin
      angle_r <= angle_nxt;
    end
  end

  assign res.angle  = angle_nxt;
  assign res.moving = ACTIVE && (mag > XW'(THRESH));

endmodule

`default_nettype wire

// ===== src/jasl_merge.sv =====
// Merge stage: folds lane moving flags, forms start/stop events, packs angles.
// Depends on jasl_pkg; holds the previous moving flag.
`timescale 1ns / 1ps
`default_nettype none

module jasl_merge (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step_en,
  input  jasl_pkg::lane_res_t       lanes [jasl_pkg::NUM_LANES],
  output jasl_pkg::result_t         res
);
  import jasl_pkg::*;

  logic was_moving_r;
  logic moving;

  always_comb begin
    moving = 1'b0;
    for (int j = 0; j < NUM_LANES; j++) begin
      moving = moving | lanes[j].moving;
      res.angles[j*ANGLE_W +: ANGLE_W] = lanes[j].angle;
    end
    res.moving = moving;
    if (was_moving_r && !moving) begin
      res.evt = EVT_STOP;
    end else if (!was_moving_r && moving) begin
      res.evt = EVT_START;
    end else begin
      res.evt = EVT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_moving_r <= 1'b0;
    end else if (step_en) begin
      was_moving_r <= moving;
    end
  end

endmodule

`default_nettype wire

// ===== src/joint_angle_slew_limiter_unit.sv =====
// A taken request's result is registered in the output register, or the skid entry on a
// stall. One request per cycle while in_tready is high; the per-joint add, wrap and clamp
// are combinational and the angle update is registered. A two-entry output buffer keeps
// input taking while one result waits. Reset (rst_n low, synchronous) zeroes all joint
// angles and the moving flag, empties the output buffer and restores register defaults.
// Depends on jasl_pkg, jasl_lane, jasl_merge and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module joint_angle_slew_limiter_unit #(
  parameter int JOINTS           = 6,
  parameter int MOTION_THRESHOLD = 1
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // target_0 .. target_5, 16 bits each from bit 0 up
  input  wire logic [jasl_pkg::NUM_LANES*jasl_pkg::ANGLE_W-1:0] in_tdata,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // current_0 .. current_5, 16 bits each from bit 0 up
  output logic [jasl_pkg::NUM_LANES*jasl_pkg::ANGLE_W-1:0]      out_tdata,
  // bit 0 is_moving, bits 2:1 event_code
  output logic [2:0]                              out_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  input  wire logic                               cfg_wr_en,
  input  wire logic [jasl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [jasl_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import jasl_pkg::*;

  logic [STEP_W-1:0]  max_step_r;
  logic [MASK_W-1:0]  dir_mask_r;
  logic [ANGLE_W-1:0] offset_r [NUM_LANES];

  lane_res_t lane_res [NUM_LANES];
  result_t   merged;
  result_t   out_q_r;
  result_t   skid_q_r;
  logic      out_valid_r;
  logic      skid_valid_r;
  logic      in_fire;
  logic      out_fire;

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_step_r <= MAX_STEP_RST;
      dir_mask_r <= '0;
      for (int j = 0; j < NUM_LANES; j++) begin
        offset_r[j] <= '0;
      end
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MAX_STEP:  max_step_r  <= cfg_wdata[STEP_W-1:0];
        REG_DIR_MASK:  dir_mask_r  <= cfg_wdata[MASK_W-1:0];
        REG_OFFSET_J0: offset_r[0] <= cfg_wdata;
        REG_OFFSET_J1: offset_r[1] <= cfg_wdata;
        REG_OFFSET_J2: offset_r[2] <= cfg_wdata;
        REG_OFFSET_J3: offset_r[3] <= cfg_wdata;
        REG_OFFSET_J4: offset_r[4] <= cfg_wdata;
        REG_OFFSET_J5: offset_r[5] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    jasl_lane #(
      .ACTIVE (g < JOINTS),
      .THRESH (MOTION_THRESHOLD)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .step_en  (in_fire),
      .neg      (dir_mask_r[g]),
      .offset   (offset_r[g]),
      .max_step (max_step_r),
      .target   (in_tdata[g*ANGLE_W +: ANGLE_W]),
      .res      (lane_res[g])
    );
  end

  jasl_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_fire),
    .lanes   (lane_res),
    .res     (merged)
  );

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (in_fire) begin
      if (!out_valid_r || out_tready) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r  <= skid_valid_r;
      skid_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (!out_valid_r || out_tready) begin
        out_q_r <= merged;
      end else begin
        skid_q_r <= merged;
      end
    end else if (out_fire && skid_valid_r) begin
      out_q_r <= skid_q_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_q_r.angles;
  assign out_tuser  = {out_q_r.evt, out_q_r.moving};

  `ASSERT_PROP(a_skid_needs_out, skid_valid_r |-> out_valid_r)
  `ASSERT_PROP(a_stall_fills_skid,
               (in_fire && out_valid_r && !out_tready) |=> skid_valid_r)
  `ASSERT_PROP(a_start_is_moving, (out_valid_r && out_q_r.evt == EVT_START) |-> out_q_r.moving)
  `ASSERT_NEVER(a_stop_while_moving, out_valid_r && out_q_r.evt == EVT_STOP && out_q_r.moving)

endmodule

`default_nettype wire
